// ===== sv/aes256_pkg.sv =====
// ----------------------------------------------------------------------------
// aes256_pkg
// Shared types, S-box tables and round helper functions for the AES-256 core.
// ----------------------------------------------------------------------------
package aes256_pkg;

  localparam int NumRounds     = 14;
  localparam int ScheduleWords = 60;
  localparam int RkRows        = ScheduleWords / 4;
  localparam int KeyRegs       = 4;

  // Controller state codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_KEXP  = 3'd1;
  localparam logic [2:0] ST_INIT  = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [3:0] RK_FIRST = 4'd0;
  localparam logic [3:0] RK_LAST  = 4'd14;
  localparam logic [5:0] KEXP_END = 6'd59;

  typedef logic [7:0] byte_t;
  typedef byte_t sbox_t [256];

  // Controller commands to the datapath
  typedef struct packed {
    logic       key_wr;
    logic [1:0] key_idx;
    logic       kexp;
    logic [5:0] kcnt;
    logic       blk_load;
    logic       ark_init;
    logic       round;
    logic       dec;
    logic       last;
    logic [3:0] raddr;
    logic       out_load;
  } aes_cmd_t;

  function automatic byte_t xt(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Elaboration-time multiply, used only to build the tables
  function automatic byte_t gf_mul_c(input byte_t a, input byte_t b);
    byte_t acc;
    byte_t p;
    acc = 8'h00;
    p   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ p;
      p = xt(p);
    end
    return acc;
  endfunction

  function automatic sbox_t gen_sbox();
    sbox_t t;
    byte_t r;
    byte_t p;
    byte_t b;
    for (int x = 0; x < 256; x++) begin
      r = 8'h01;
      p = x[7:0];
      // a^254 = inverse, zero maps to zero
      for (int e = 0; e < 8; e++) begin
        if (((254 >> e) & 1) == 1) r = gf_mul_c(r, p);
        p = gf_mul_c(p, p);
      end
      b = r;
      t[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
             ^ {b[3:0], b[7:4]} ^ 8'h63;
    end
    return t;
  endfunction

  function automatic sbox_t gen_inv_sbox();
    sbox_t f;
    sbox_t t;
    f = gen_sbox();
    for (int x = 0; x < 256; x++) t[f[x]] = x[7:0];
    return t;
  endfunction

  localparam sbox_t SBOX     = gen_sbox();
  localparam sbox_t INV_SBOX = gen_inv_sbox();

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte k of the state sits at bits [127-8k -: 8]; byte r+4c is row r, column c
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int k = 0; k < 16; k++)
      t[127-8*k -: 8] = inv ? INV_SBOX[s[127-8*k -: 8]] : SBOX[s[127-8*k -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (inv) t[127-8*(r+4*((c+r)&3)) -: 8] = s[127-8*(r+4*c) -: 8];
        else     t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)&3)) -: 8];
      end
    return t;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
    byte_t a [4];
    byte_t x2 [4];
    byte_t x4 [4];
    byte_t x8 [4];
    logic [31:0] o;
    for (int k = 0; k < 4; k++) begin
      a[k]  = col[31-8*k -: 8];
      x2[k] = xt(a[k]);
      x4[k] = xt(x2[k]);
      x8[k] = xt(x4[k]);
    end
    for (int r = 0; r < 4; r++) begin
      if (inv)
        o[31-8*r -: 8] = (x8[r] ^ x4[r] ^ x2[r])
                       ^ (x8[(r+1)&3] ^ x2[(r+1)&3] ^ a[(r+1)&3])
                       ^ (x8[(r+2)&3] ^ x4[(r+2)&3] ^ a[(r+2)&3])
                       ^ (x8[(r+3)&3] ^ a[(r+3)&3]);
      else
        o[31-8*r -: 8] = x2[r] ^ (x2[(r+1)&3] ^ a[(r+1)&3]) ^ a[(r+2)&3] ^ a[(r+3)&3];
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) t[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
    return t;
  endfunction

endpackage

// ===== sv/aes256_dp.sv =====
// ----------------------------------------------------------------------------
// aes256_dp
// Key registers, key expansion window, round-key memory and shared round unit.
// ----------------------------------------------------------------------------
module aes256_dp
  import aes256_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  aes_cmd_t      cmd,
  input  logic [63:0]   cfg_data,
  input  logic [63:0]   blk_hi,
  input  logic [63:0]   blk_lo,
  output logic [63:0]   res_hi,
  output logic [63:0]   res_lo
);

  logic [255:0] key_r;
  logic [31:0]  win_r [8];
  logic [127:0] rk_mem [RkRows];
  logic [127:0] rk_q_r;
  logic [127:0] st_r;
  logic [127:0] out_r;

  logic [31:0]  nw;
  logic [31:0]  t_word;
  logic [7:0]   rcon;
  logic [127:0] enc_out;
  logic [127:0] dec_out;
  logic [127:0] sr_e;
  logic [127:0] ak_d;

  // Next schedule word from the sliding window of the last eight words
  always_comb begin
    rcon = 8'h01 << (cmd.kcnt[5:3] - 3'd1);
    t_word = win_r[7];
    if (cmd.kcnt[2:0] == 3'd0)
      t_word = sub_word({win_r[7][23:0], win_r[7][31:24]}) ^ {rcon, 24'h0};
    else if (cmd.kcnt[2:0] == 3'd4)
      t_word = sub_word(win_r[7]);
    if (cmd.kcnt < 6'd8) nw = key_r[255 - 32*cmd.kcnt[2:0] -: 32];
    else                 nw = win_r[0] ^ t_word;
  end

  // Shared round unit
  always_comb begin
    sr_e    = shift_rows(sub_bytes(st_r, 1'b0), 1'b0);
    enc_out = (cmd.last ? sr_e : mix_columns(sr_e, 1'b0)) ^ rk_q_r;
    ak_d    = sub_bytes(shift_rows(st_r, 1'b1), 1'b1) ^ rk_q_r;
    dec_out = cmd.last ? ak_d : mix_columns(ak_d, 1'b1);
  end

  // Key registers, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cmd.key_wr) begin
      key_r[255 - 64*cmd.key_idx -: 64] <= cfg_data;
    end
  end

  // Advance the expansion window
  always_ff @(posedge clk) begin
    if (cmd.kexp) begin
      for (int j = 0; j < 7; j++) win_r[j] <= win_r[j+1];
      win_r[7] <= nw;
    end
  end

  // Round-key memory: one row write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.kexp && cmd.kcnt[1:0] == 2'd3)
      rk_mem[cmd.kcnt[5:2]] <= {win_r[5], win_r[6], win_r[7], nw};
    rk_q_r <= rk_mem[cmd.raddr];
  end

  // Working block
  always_ff @(posedge clk) begin
    if (cmd.blk_load)      st_r <= {blk_hi, blk_lo};
    else if (cmd.ark_init) st_r <= st_r ^ rk_q_r;
    else if (cmd.round)    st_r <= cmd.dec ? dec_out : enc_out;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) out_r <= st_r;
  end

  assign res_hi = out_r[127:64];
  assign res_lo = out_r[63:0];

endmodule

// ===== sv/aes256_ctrl.sv =====
// ----------------------------------------------------------------------------
// aes256_ctrl
// Sequencer for key expansion and the round loop, plus result handshake.
// ----------------------------------------------------------------------------
module aes256_ctrl
  import aes256_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  output logic       out_valid,
  input  logic       out_ready,
  output aes_cmd_t   cmd
);

  logic [2:0] state_r, state_nxt;
  logic [5:0] kcnt_r, kcnt_nxt;
  logic [3:0] rnd_r, rnd_nxt;
  logic       dec_r, dec_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       last;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign out_valid = out_valid_r;
  assign last      = dec_r ? (rnd_r == RK_FIRST) : (rnd_r == RK_LAST);

  always_comb begin
    state_nxt     = state_r;
    kcnt_nxt      = kcnt_r;
    rnd_nxt       = rnd_r;
    dec_nxt       = dec_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.kcnt      = kcnt_r;
    cmd.dec       = dec_r;
    cmd.last      = last;
    cmd.key_idx   = cfg_index[1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          // drop writes beyond the key registers
          if (cfg_index < 3'(KeyRegs)) begin
            cmd.key_wr = 1'b1;
            kcnt_nxt   = '0;
            state_nxt  = ST_KEXP;
          end
        end else if (in_valid) begin
          cmd.blk_load = 1'b1;
          dec_nxt      = in_func;
          cmd.raddr    = in_func ? RK_LAST : RK_FIRST;
          state_nxt    = ST_INIT;
        end
      end
      ST_KEXP: begin
        cmd.kexp = 1'b1;
        kcnt_nxt = kcnt_r + 6'd1;
        if (kcnt_r == KEXP_END) state_nxt = ST_IDLE;
      end
      ST_INIT: begin
        cmd.ark_init = 1'b1;
        rnd_nxt      = dec_r ? RK_LAST - 4'd1 : RK_FIRST + 4'd1;
        cmd.raddr    = rnd_nxt;
        state_nxt    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (last) begin
          state_nxt = ST_DONE;
        end else begin
          rnd_nxt   = dec_r ? rnd_r - 4'd1 : rnd_r + 4'd1;
          cmd.raddr = rnd_nxt;
        end
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kcnt_r      <= '0;
      rnd_r       <= '0;
      dec_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kcnt_r      <= kcnt_nxt;
      rnd_r       <= rnd_nxt;
      dec_r       <= dec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/aes256_block_cipher.sv =====
// Each block passes through the key add, 14 rounds and the result transfer, one block
//   at a time through the round unit.
// The next block is taken while a result waits, but only once the round unit is free.
// A key register write expands all 60 schedule words, one schedule word per cycle.
// Reset (rst_n low, synchronous) clears the sequencer, result valid and key
//   registers; keys are not expanded until the first key write.
// ----------------------------------------------------------------------------
// aes256_block_cipher
// AES-256 ECB encrypt/decrypt core with a shared iterative round unit.
// ----------------------------------------------------------------------------
module aes256_block_cipher
  import aes256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_hi,
  output logic [63:0] out_result_lo
);

  aes_cmd_t cmd;

  aes256_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  aes256_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg_data (cfg_data),
    .blk_hi   (in_block_hi),
    .blk_lo   (in_block_lo),
    .res_hi   (out_result_hi),
    .res_lo   (out_result_lo)
  );

endmodule

// ===== tb/aes256_block_cipher_checker.sv =====
// ----------------------------------------------------------------------------
// aes256_block_cipher_checker
// Watches the key, block and result channels of the AES-256 core. Expands the
// key on every key register write, computes the cipher or inverse cipher
// output for each accepted block, and compares each accepted result with the
// oldest pending one.
// ----------------------------------------------------------------------------
module aes256_block_cipher_checker
  import aes256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_func,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_result_hi,
  input  logic [63:0] out_result_lo,
  output int          error_count,
  output int          pending_blocks
);

  localparam logic DIR_ENCRYPT = 1'b0;

  logic [63:0]  key_regs [KeyRegs];
  logic [31:0]  sched [ScheduleWords];
  logic [127:0] cipher_q [$];

  // GF(2^8) arithmetic, written out from the field definition
  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_prod(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_dbl(a);
    end
    return acc;
  endfunction

  function automatic logic [7:0] gf_recip(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h01;
    p = a;
    for (int e = 0; e < 8; e++) begin
      if ((254 >> e) & 1) r = gf_prod(r, p);
      p = gf_prod(p, p);
    end
    return r;
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] x, input int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] fwd_sub(input logic [7:0] x);
    logic [7:0] b;
    b = gf_recip(x);
    return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] rev_sub(input logic [7:0] s);
    return gf_recip(rol8(s, 1) ^ rol8(s, 3) ^ rol8(s, 6) ^ 8'h05);
  endfunction

  function automatic logic [31:0] fwd_sub_word(input logic [31:0] w);
    return {fwd_sub(w[31:24]), fwd_sub(w[23:16]), fwd_sub(w[15:8]), fwd_sub(w[7:0])};
  endfunction

  // Rebuild all 60 schedule words from the key registers
  task automatic expand_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < KeyRegs; i++) begin
      sched[2*i]   = key_regs[i][63:32];
      sched[2*i+1] = key_regs[i][31:0];
    end
    for (int i = 8; i < ScheduleWords; i++) begin
      t = sched[i-1];
      if ((i & 7) == 0) begin
        t  = fwd_sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_dbl(rc);
      end else if ((i & 7) == 4) begin
        t = fwd_sub_word(t);
      end
      sched[i] = sched[i-8] ^ t;
    end
  endtask

  // st[r][c] holds row r, column c
  typedef logic [7:0] grid_t [4][4];

  function automatic grid_t add_key(input grid_t st, input int rnd);
    logic [31:0] w;
    for (int c = 0; c < 4; c++) begin
      w = sched[4*rnd + c];
      for (int r = 0; r < 4; r++) st[r][c] ^= w[31-8*r -: 8];
    end
    return st;
  endfunction

  function automatic grid_t rotate_rows(input grid_t st, input logic inv);
    grid_t t;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        if (inv) t[r][(c+r)&3] = st[r][c];
        else     t[r][c] = st[r][(c+r)&3];
      end
    return t;
  endfunction

  function automatic grid_t mix_grid(input grid_t st, input logic inv);
    logic [7:0] coef [4];
    grid_t t;
    if (inv) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else     coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        t[r][c] = 8'h00;
        for (int k = 0; k < 4; k++) t[r][c] ^= gf_prod(coef[(k-r)&3], st[k][c]);
      end
    return t;
  endfunction

  function automatic logic [127:0] cipher_block(input logic dir, input logic [127:0] blk);
    grid_t st;
    logic [127:0] res;
    for (int k = 0; k < 16; k++) st[k%4][k/4] = blk[127-8*k -: 8];
    if (dir == DIR_ENCRYPT) begin
      st = add_key(st, 0);
      for (int rnd = 1; rnd <= NumRounds; rnd++) begin
        for (int k = 0; k < 16; k++) st[k%4][k/4] = fwd_sub(st[k%4][k/4]);
        st = rotate_rows(st, 1'b0);
        if (rnd != NumRounds) st = mix_grid(st, 1'b0);
        st = add_key(st, rnd);
      end
    end else begin
      st = add_key(st, NumRounds);
      for (int rnd = NumRounds - 1; rnd >= 0; rnd--) begin
        st = rotate_rows(st, 1'b1);
        for (int k = 0; k < 16; k++) st[k%4][k/4] = rev_sub(st[k%4][k/4]);
        st = add_key(st, rnd);
        if (rnd != 0) st = mix_grid(st, 1'b1);
      end
    end
    for (int k = 0; k < 16; k++) res[127-8*k -: 8] = st[k%4][k/4];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  initial begin
    error_count = 0;
    pending_blocks = 0;
    foreach (key_regs[i]) key_regs[i] = '0;
    foreach (sched[i]) sched[i] = '0;
  end

  // Track each transaction at the rising edge
  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready && cfg_index < KeyRegs) begin
        key_regs[cfg_index[1:0]] = cfg_data;
        expand_schedule();
      end
      if (in_valid && in_ready)
        cipher_q.push_back(cipher_block(in_func, {in_block_hi, in_block_lo}));
      if (out_valid && out_ready) begin
        if (cipher_q.size() == 0) begin
          report_mismatch("unexpected result_hi", out_result_hi, 'x);
        end else begin
          want = cipher_q.pop_front();
          if (out_result_hi !== want[127:64])
            report_mismatch("result_hi", out_result_hi, want[127:64]);
          if (out_result_lo !== want[63:0])
            report_mismatch("result_lo", out_result_lo, want[63:0]);
        end
      end
      pending_blocks = cipher_q.size();
    end
  end

endmodule

// ===== tb/aes256_block_cipher_test.sv =====
// ----------------------------------------------------------------------------
// aes256_block_cipher_test
// Drives keys and blocks into the AES-256 core with random gaps and output
// stalls, including one long output stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module aes256_block_cipher_test;
  import aes256_pkg::*;

  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;
  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_BAD  = 3'd5;
  localparam logic [2:0] REG_TOP  = 3'd7;
  localparam int RANDOM_BLOCKS = 600;
  localparam int SETTLE_CYCLES = 80;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic [63:0] in_block_hi;
  logic [63:0] in_block_lo;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_result_hi;
  logic [63:0] out_result_lo;
  int          error_count;
  int          pending_blocks;
  bit          long_stall;
  bit          stall_done;

  aes256_block_cipher dut (.*);

  aes256_block_cipher_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  task automatic idle_cycles(input int n);
    repeat (n) @(negedge clk);
  endtask

  // Write one key register, then drop valid again
  task automatic write_key(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_all_keys(input logic [63:0] k0, input logic [63:0] k1,
                               input logic [63:0] k2, input logic [63:0] k3);
    write_key(REG_KEY0, k0);
    write_key(REG_KEY1, k1);
    write_key(REG_KEY2, k2);
    write_key(REG_KEY3, k3);
  endtask

  // Offer one block; valid stays up across back-to-back transactions
  task automatic send_block(input logic fn, input logic [63:0] hi, input logic [63:0] lo);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      idle_cycles(gap);
    end
    in_valid    <= 1'b1;
    in_func     <= fn;
    in_block_hi <= hi;
    in_block_lo <= lo;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_blocks != 0) @(negedge clk);
    idle_cycles(SETTLE_CYCLES);
  endtask

  // Receiver: random wait before each result, one long hold-off on request
  initial begin
    int gap;
    out_ready = 1'b0;
    stall_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_stall && !stall_done) begin
        out_ready <= 1'b0;
        idle_cycles(200);
        stall_done = 1'b1;
      end
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready <= 1'b0;
        idle_cycles(gap);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    #40000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic fn;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_func = FUNC_ENC;
    in_block_hi = '0;
    in_block_lo = '0;
    long_stall = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Standard test vector key, then its known plaintext both ways
    load_all_keys(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                  64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_block(FUNC_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(FUNC_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    send_block(FUNC_ENC, '0, '0);
    send_block(FUNC_ENC, '1, '1);
    send_block(FUNC_DEC, '0, '0);
    send_block(FUNC_DEC, '1, '1);
    drain();

    // All-zero and all-one keys, a partial update, two ignored indices
    load_all_keys('0, '0, '0, '0);
    send_block(FUNC_ENC, '0, '0);
    send_block(FUNC_DEC, '1, '0);
    drain();
    load_all_keys('1, '1, '1, '1);
    send_block(FUNC_ENC, '0, '1);
    send_block(FUNC_DEC, '1, '1);
    drain();
    write_key(REG_KEY2, 64'h0123456789abcdef);
    write_key(REG_BAD, 64'hdeadbeefdeadbeef);
    write_key(REG_TOP, 64'h5555aaaa5555aaaa);
    send_block(FUNC_ENC, 64'h8000000000000000, 64'h0000000000000001);
    send_block(FUNC_DEC, 64'h0000000000000001, 64'h8000000000000000);
    drain();

    // Random phases with fresh keys; the long output hold-off lands in the first
    for (int ph = 0; ph < 6; ph++) begin
      load_all_keys(pick_word(), pick_word(), pick_word(), pick_word());
      if (ph == 0) long_stall = 1'b1;
      for (int i = 0; i < RANDOM_BLOCKS / 6; i++) begin
        fn = 1'($urandom_range(0, 1));
        send_block(fn, pick_word(), pick_word());
      end
      drain();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/aes256_pkg.sv
sv/aes256_dp.sv
sv/aes256_ctrl.sv
sv/aes256_block_cipher.sv
tb/aes256_block_cipher_checker.sv
tb/aes256_block_cipher_test.sv
